>>> src/htfc_pkg.sv
// htfc_pkg: shared types, constants and the CRC-8 byte update for the
// humidity/temperature frame checker. No dependencies.
`default_nettype none

package htfc_pkg;

	// CRC-8, poly x^8+x^5+x^4+1, MSB first
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_MSB  = 8'h80;

	// byte positions inside one six-byte frame
	localparam logic [2:0] POS_TEMP_HI  = 3'd0;
	localparam logic [2:0] POS_TEMP_LO  = 3'd1;
	localparam logic [2:0] POS_TEMP_CRC = 3'd2;
	localparam logic [2:0] POS_HUM_HI   = 3'd3;
	localparam logic [2:0] POS_HUM_LO   = 3'd4;
	localparam logic [2:0] POS_HUM_CRC  = 3'd5;
	localparam logic [2:0] FRAME_LAST   = POS_HUM_CRC;

	// conversion: temp = 175*raw/65535 - 45, hum = 100*raw/65535
	localparam logic [7:0]        TEMP_SCALE  = 8'd175;
	localparam logic [7:0]        HUM_SCALE   = 8'd100;
	localparam logic signed [8:0] TEMP_OFFSET = 9'sd45;

	// register reset values
	localparam logic signed [8:0] TEMP_MIN_RST = -9'sd20;
	localparam logic signed [8:0] TEMP_MAX_RST = 9'sd125;
	localparam logic [6:0]        HUM_MIN_RST  = 7'd1;
	localparam logic [6:0]        HUM_MAX_RST  = 7'd100;

	typedef enum logic [1:0] {
		REG_TEMP_MIN = 2'd0,
		REG_TEMP_MAX = 2'd1,
		REG_HUM_MIN  = 2'd2,
		REG_HUM_MAX  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CRC_ERR = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [8:0] temp_min;
		logic signed [8:0] temp_max;
		logic [6:0]        hum_min;
		logic [6:0]        hum_max;
	} cfg_t;

	// one complete frame handed from the byte assembler to the converter
	typedef struct packed {
		logic [15:0] temp_raw;
		logic [15:0] hum_raw;
		logic        temp_ok;
		logic        hum_ok;
	} frame_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 8'd0) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/htfc_frame.sv
// htfc_frame: byte position tracking, CRC-8 check and raw word assembly.
// Depends on htfc_pkg.
`default_nettype none

module htfc_frame (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      data_byte,
	input  wire logic            frame_start,
	output logic                 frame_done,
	output htfc_pkg::frame_t     frame
);
	import htfc_pkg::*;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_raw_q;
	logic [15:0] hum_raw_q;
	logic        temp_ok_q;

	logic [2:0]  pos;
	logic [2:0]  pos_next;
	logic [7:0]  crc_base;
	logic [7:0]  crc_upd;
	logic [7:0]  crc_next;
	logic [15:0] temp_raw_next;
	logic [15:0] hum_raw_next;
	logic        temp_ok_next;

	always_comb begin
		pos      = pos_q;
		crc_base = crc_q;
		// start flag or a stray position restarts the frame
		if (frame_start || pos_q > FRAME_LAST) begin
			pos      = POS_TEMP_HI;
			crc_base = CRC_INIT;
		end
		crc_upd       = crc8_byte(crc_base, data_byte);
		crc_next      = crc_base;
		temp_raw_next = temp_raw_q;
		hum_raw_next  = hum_raw_q;
		temp_ok_next  = temp_ok_q;
		case (pos)
			POS_TEMP_HI: begin
				temp_raw_next = {data_byte, 8'h00};
				crc_next      = crc_upd;
			end
			POS_TEMP_LO: begin
				temp_raw_next = {temp_raw_q[15:8], data_byte};
				crc_next      = crc_upd;
			end
			POS_TEMP_CRC: begin
				temp_ok_next = (crc_base == data_byte);
				crc_next     = CRC_INIT;
			end
			POS_HUM_HI: begin
				hum_raw_next = {data_byte, 8'h00};
				crc_next     = crc_upd;
			end
			POS_HUM_LO: begin
				hum_raw_next = {hum_raw_q[15:8], data_byte};
				crc_next     = crc_upd;
			end
			POS_HUM_CRC: begin
				crc_next = CRC_INIT;
			end
			default: begin
				crc_next = crc_base;
			end
		endcase
		frame_done = (pos == FRAME_LAST);
		pos_next   = frame_done ? POS_TEMP_HI : pos + 3'd1;
	end

	assign frame.temp_raw = temp_raw_q;
	assign frame.hum_raw  = hum_raw_q;
	assign frame.temp_ok  = temp_ok_q;
	assign frame.hum_ok   = (crc_base == data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_TEMP_HI;
			crc_q      <= CRC_INIT;
			temp_raw_q <= 16'd0;
			hum_raw_q  <= 16'd0;
			temp_ok_q  <= 1'b0;
		end else if (accept) begin
			pos_q      <= pos_next;
			crc_q      <= crc_next;
			temp_raw_q <= temp_raw_next;
			hum_raw_q  <= hum_raw_next;
			temp_ok_q  <= temp_ok_next;
		end
	end

endmodule

`default_nettype wire

>>> src/htfc_convert.sv
// htfc_convert: frame register, scaling, range check and result register,
// with the stall control of both stages. Depends on htfc_pkg.
`default_nettype none

module htfc_convert (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire htfc_pkg::frame_t    frame,
	input  wire htfc_pkg::cfg_t      cfg,
	output logic                     can_take,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [8:0]        temperature,
	output logic [6:0]               humidity,
	output logic                     temp_crc_ok,
	output logic                     hum_crc_ok,
	output htfc_pkg::status_t        status
);
	import htfc_pkg::*;

	// floor(x / 65535) for x < 256*65535: q = (x + (x >> 16) + 1) >> 16
	function automatic logic [7:0] div_ffff(input logic [23:0] x);
		logic [24:0] s;
		s = {1'b0, x} + {17'd0, x[23:16]} + 25'd1;
		return s[23:16];
	endfunction

	logic   vld_s1;
	frame_t frm_s1;

	logic              vld_s2;
	logic signed [8:0] temp_s2;
	logic [6:0]        hum_s2;
	logic              temp_ok_s2;
	logic              hum_ok_s2;
	status_t           status_s2;

	logic              adv_s1;
	logic              adv_s2;
	logic [23:0]       temp_prod;
	logic [23:0]       hum_prod;
	logic [7:0]        temp_q;
	logic [7:0]        hum_q;
	logic signed [8:0] temp_val;
	logic [6:0]        hum_val;
	logic              in_range;
	status_t           status_val;

	assign adv_s2   = !vld_s2 || out_ready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign can_take = adv_s1;

	always_comb begin
		temp_prod = {8'd0, frm_s1.temp_raw} * {16'd0, TEMP_SCALE};
		hum_prod  = {8'd0, frm_s1.hum_raw} * {16'd0, HUM_SCALE};
		temp_q    = div_ffff(temp_prod);
		hum_q     = div_ffff(hum_prod);
		temp_val  = $signed({1'b0, temp_q}) - TEMP_OFFSET;
		hum_val   = hum_q[6:0];
		in_range  = (temp_val >= $signed(cfg.temp_min)) && (temp_val <= $signed(cfg.temp_max))
			&& (hum_val >= cfg.hum_min) && (hum_val <= cfg.hum_max);
		if (!(frm_s1.temp_ok && frm_s1.hum_ok)) begin
			status_val = ST_CRC_ERR;
		end else if (!in_range) begin
			status_val = ST_RANGE;
		end else begin
			status_val = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= load;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && load) begin
			frm_s1 <= frame;
		end
		if (adv_s2 && vld_s1) begin
			temp_s2    <= temp_val;
			hum_s2     <= hum_val;
			temp_ok_s2 <= frm_s1.temp_ok;
			hum_ok_s2  <= frm_s1.hum_ok;
			status_s2  <= status_val;
		end
	end

	assign out_valid   = vld_s2;
	assign temperature = temp_s2;
	assign humidity    = hum_s2;
	assign temp_crc_ok = temp_ok_s2;
	assign hum_crc_ok  = hum_ok_s2;
	assign status      = status_s2;

endmodule

`default_nettype wire

>>> src/humidity_temperature_frame_check_top.sv
// humidity_temperature_frame_check_top: top level, range registers and checks.
// Depends on htfc_pkg, htfc_frame and htfc_convert.
//
// Usage:
//  - Input channel (in_valid/in_ready): one beat carries one frame byte
//    (data_byte) and frame_start. Frame order: temp hi, temp lo, temp CRC,
//    hum hi, hum lo, hum CRC. frame_start forces the beat to byte 0 and
//    restarts the CRC; without it, frames simply follow one another.
//  - Output channel (out_valid/out_ready): one beat per completed frame with
//    temperature (signed degrees), humidity (percent), both CRC flags and
//    status (0 accepted, 1 CRC error, 2 out of range; CRC error wins).
//  - Config port: wr_en/wr_index/wr_data write one of temp_min, temp_max,
//    hum_min, hum_max, picked by wr_index; write only while the block is idle.
//  - Throughput: one byte per cycle while in_ready is high. The CRC update
//    sits between the input beat and the frame register; scaling and range
//    check sit between the frame register and the result register.
//  - Result path: the sixth byte's beat loads the frame register; from there
//    the result moves into the result register, which drives out_valid.
//  - Stall: the result register holds while out_ready is low; the frame
//    register still takes one more frame, after which in_ready drops.
//  - Reset (arst_n low): byte position 0, CRC 0xFF, pipeline empty, range
//    registers back to -20..125 degrees and 1..100 percent.
`default_nettype none

module humidity_temperature_frame_check_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              frame_start,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [8:0]      temperature,
	output logic [6:0]             humidity,
	output logic                   temp_crc_ok,
	output logic                   hum_crc_ok,
	output logic [1:0]             status,
	input  wire logic              wr_en,
	input  wire logic [1:0]        wr_index,
	input  wire logic [8:0]        wr_data
);
	import htfc_pkg::*;

	cfg_t    cfg_q;
	frame_t  frame;
	status_t status_int;
	logic    accept;
	logic    frame_done;
	logic    can_take;

	// range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_min <= TEMP_MIN_RST;
			cfg_q.temp_max <= TEMP_MAX_RST;
			cfg_q.hum_min  <= HUM_MIN_RST;
			cfg_q.hum_max  <= HUM_MAX_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_TEMP_MIN: cfg_q.temp_min <= $signed(wr_data);
				REG_TEMP_MAX: cfg_q.temp_max <= $signed(wr_data);
				REG_HUM_MIN:  cfg_q.hum_min  <= wr_data[6:0];
				REG_HUM_MAX:  cfg_q.hum_max  <= wr_data[6:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	assign in_ready = can_take;
	assign accept   = in_valid && in_ready;

	htfc_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.frame_done  (frame_done),
		.frame       (frame)
	);

	htfc_convert u_convert (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept && frame_done),
		.frame       (frame),
		.cfg         (cfg_q),
		.can_take    (can_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.temperature (temperature),
		.humidity    (humidity),
		.temp_crc_ok (temp_crc_ok),
		.hum_crc_ok  (hum_crc_ok),
		.status      (status_int)
	);

	assign status = status_int;

	// checks

	// status code tracks the two CRC flags
	a_crc_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_CRC_ERR) == !(temp_crc_ok && hum_crc_ok)))
		else $error("status does not match CRC flags");

	// converted values stay within the sensor span and status is a defined code
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (humidity <= 7'd100 && temperature >= -9'sd45
			&& temperature <= 9'sd130 && status != 2'd3))
		else $error("converted value outside sensor span");

	// an accepted result lies inside the configured window
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |-> (temperature >= cfg_q.temp_min
			&& temperature <= cfg_q.temp_max && humidity >= cfg_q.hum_min
			&& humidity <= cfg_q.hum_max))
		else $error("accepted result outside range window");

	// input side only stalls behind a blocked result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("in_ready low without output stall");

endmodule

`default_nettype wire
